// File: design/cwmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Credit window message tracker package
// Shared types and constants for the tracker's front end, back end and queues.
// ----------------------------------------------------------------------------
package cwmt_pkg;

	localparam int RING_DEPTH = 8;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int TAG_W      = 8;
	localparam int QSEQ_W     = 16;
	localparam int KIND_W     = 3;
	localparam int OPC_W      = 3;
	localparam int CODE_W     = 3;

	// Messages kept in the ring while one slot stays free and one is held back.
	localparam int QUEUE_SPAN = RING_DEPTH - 2;

	typedef enum logic [OPC_W-1:0] {
		OP_ADD    = 3'd0,
		OP_SEND   = 3'd1,
		OP_ACK    = 3'd2,
		OP_LOST   = 3'd3,
		OP_PURGE  = 3'd4,
		OP_RESET  = 3'd5,
		OP_STATUS = 3'd6,
		OP_NONE   = 3'd7
	} op_t;

	typedef enum logic [CODE_W-1:0] {
		ST_OK        = 3'd0,
		ST_RING_FULL = 3'd1,
		ST_WINDOW    = 3'd2,
		ST_DEVQ_FULL = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// Message kinds; linear, cubic and dwell are movement kinds.
	localparam logic [KIND_W-1:0] KIND_LINEAR = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DWELL  = 3'd2;

	// Configuration register indexes.
	localparam logic REG_DEVICE_QUEUE_LIMIT = 1'b0;
	localparam logic REG_WINDOW_MINIMUM     = 1'b1;

	localparam logic [QSEQ_W-1:0] DEVICE_QUEUE_LIMIT_RESET = 16'd23;
	localparam logic [TAG_W-1:0]  WINDOW_MINIMUM_RESET     = 8'd3;

	typedef struct packed {
		op_t               op;
		logic              is_move;
		logic [TAG_W-1:0]  seq_number;
		logic [TAG_W-1:0]  window_credit;
		logic [QSEQ_W-1:0] device_current_qseq;
		logic [QSEQ_W-1:0] device_end_qseq;
	} cmd_t;

	typedef struct packed {
		logic              accepted;
		status_t           status_code;
		logic [PTR_W-1:0]  slot;
		logic [TAG_W-1:0]  msg_seq;
		logic [QSEQ_W-1:0] queue_seq;
		logic              sequenced;
		logic [PTR_W-1:0]  messages_held;
		logic [PTR_W-1:0]  queue_left;
	} res_t;

endpackage

// File: design/credit_window_message_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Credit window message tracker
// Transmit-side tracker for a ring of outgoing messages with window credit.
// ----------------------------------------------------------------------------
// Path: a request is written into the command queue, executed by the back end
// and written into the result queue, where empty goes low and it can be popped.
// Throughput: one request per cycle while the result queue has room; the back
// end's update of pointers, tags and counters for each command sets that rate.
// Reset: arst_n clears all pointers, tags, counters and both queues at once;
// the configuration registers return to a limit of 23 and a minimum of 3.
// ----------------------------------------------------------------------------
module credit_window_message_tracker #(
	parameter int CMD_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,

	// Request side, queue style.
	input  logic        push,
	output logic        full,
	input  logic [2:0]  opcode,
	input  logic [2:0]  msg_kind,
	input  logic [7:0]  seq_number,
	input  logic [7:0]  window_credit,
	input  logic [15:0] device_current_qseq,
	input  logic [15:0] device_end_qseq,

	// Result side, queue style.
	output logic        empty,
	input  logic        pop,
	output logic        accepted,
	output logic [2:0]  status_code,
	output logic [2:0]  slot,
	output logic [7:0]  msg_seq,
	output logic [15:0] queue_seq,
	output logic        sequenced,
	output logic [2:0]  messages_held,
	output logic [2:0]  queue_left,

	// Configuration writes, taken in any cycle.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// The front end decodes each request into a command and drops it in a
	// short command queue; the back end drains that queue one command per
	// cycle whenever the result queue has room, so either side can stall
	// without holding up the other.

	cwmt_pkg::cmd_t cmd_in;
	cwmt_pkg::cmd_t cmd_out;
	cwmt_pkg::res_t res_in;
	cwmt_pkg::res_t res_out;
	logic           cmd_push;
	logic           cmd_pop;
	logic           cmd_empty;
	logic           res_push;
	logic           res_full;

	assign cfg_ready = 1'b1;

	cwmt_front u_front (
		.push                (push),
		.cmd_full            (full),
		.opcode              (opcode),
		.msg_kind            (msg_kind),
		.seq_number          (seq_number),
		.window_credit       (window_credit),
		.device_current_qseq (device_current_qseq),
		.device_end_qseq     (device_end_qseq),
		.cmd_push            (cmd_push),
		.cmd                 (cmd_in)
	);

	cwmt_fifo #(
		.WIDTH ($bits(cwmt_pkg::cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_in),
		.full    (full),
		.pop     (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	// The back end owns the ring state and the two configuration registers.
	cwmt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Results wait here until popped, so a stalled consumer never blocks
	// the back end from taking the next request while space remains.
	cwmt_fifo #(
		.WIDTH ($bits(cwmt_pkg::res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign accepted      = res_out.accepted;
	assign status_code   = res_out.status_code;
	assign slot          = res_out.slot;
	assign msg_seq       = res_out.msg_seq;
	assign queue_seq     = res_out.queue_seq;
	assign sequenced     = res_out.sequenced;
	assign messages_held = res_out.messages_held;
	assign queue_left    = res_out.queue_left;

endmodule

// File: design/cwmt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker queue
// Small first-in first-out buffer of flip-flops with a show-ahead read port.
// ----------------------------------------------------------------------------
module cwmt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("queue count exceeds depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not grow on a lone push");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> count_q == $past(count_q) - CW'(1))
		else $error("queue count did not shrink on a lone pop");
`endif

endmodule

// File: design/cwmt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker front end
// Accepts requests and classifies opcode and message kind into a command.
// ----------------------------------------------------------------------------
module cwmt_front (
	input  logic                       push,
	input  logic                       cmd_full,
	input  logic [cwmt_pkg::OPC_W-1:0]  opcode,
	input  logic [cwmt_pkg::KIND_W-1:0] msg_kind,
	input  logic [cwmt_pkg::TAG_W-1:0]  seq_number,
	input  logic [cwmt_pkg::TAG_W-1:0]  window_credit,
	input  logic [cwmt_pkg::QSEQ_W-1:0] device_current_qseq,
	input  logic [cwmt_pkg::QSEQ_W-1:0] device_end_qseq,
	output logic                       cmd_push,
	output cwmt_pkg::cmd_t             cmd
);

	assign cmd_push = push && !cmd_full;

	always_comb begin
		cmd                     = '0;
		cmd.op                  = cwmt_pkg::op_t'(opcode);
		// Only linear, cubic and dwell moves take a queue sequence stamp.
		cmd.is_move             = msg_kind inside {[cwmt_pkg::KIND_LINEAR:cwmt_pkg::KIND_DWELL]};
		cmd.seq_number          = seq_number;
		cmd.window_credit       = window_credit;
		cmd.device_current_qseq = device_current_qseq;
		cmd.device_end_qseq     = device_end_qseq;
	end

endmodule

// File: design/cwmt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker back end
// Executes one command per cycle, while the result queue has room, against the slot ring and counters.
// ----------------------------------------------------------------------------
module cwmt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic                       cfg_index,
	input  logic [cwmt_pkg::QSEQ_W-1:0] cfg_data,
	input  cwmt_pkg::cmd_t             cmd,
	input  logic                       cmd_empty,
	output logic                       cmd_pop,
	input  logic                       res_full,
	output logic                       res_push,
	output cwmt_pkg::res_t             res
);

	localparam int RD = cwmt_pkg::RING_DEPTH;
	localparam int PW = cwmt_pkg::PTR_W;
	localparam int TW = cwmt_pkg::TAG_W;
	localparam int QW = cwmt_pkg::QSEQ_W;

	logic [TW-1:0] tags_q [RD];
	logic [TW-1:0] tags_n [RD];
	logic          move_q [RD];
	logic [PW-1:0] head_q, head_n;
	logic [PW-1:0] tail_q, tail_n;
	logic [TW-1:0] next_seq_q, next_seq_n;
	logic [TW-1:0] last_ack_q, last_ack_n;
	logic          ack_seen_q, ack_seen_n;
	logic [QW-1:0] next_qseq_q, next_qseq_n;
	logic [TW-1:0] window_q, window_n;
	logic [QW-1:0] partner_cur_q, partner_cur_n;
	logic [QW-1:0] partner_end_q, partner_end_n;
	logic [QW-1:0] dev_limit_q;
	logic [TW-1:0] win_min_q;

	logic          exec;
	logic          add_ok;
	logic          ring_full;
	logic [QW-1:0] fill;
	logic          lost_found;
	logic [PW-1:0] lost_slot;
	logic [TW-1:0] tag_gap;
	logic [TW-1:0] resync_seq;
	logic [PW-1:0] held;

	assign exec     = !cmd_empty && !res_full;
	assign cmd_pop  = exec;
	assign res_push = exec;

	assign ring_full  = ((head_q + PW'(1)) == tail_q);
	assign add_ok     = exec && (cmd.op == cwmt_pkg::OP_ADD) && !ring_full;
	assign fill       = partner_end_q - partner_cur_q;
	assign resync_seq = last_ack_q + TW'(1);

	// Lowest slot whose tag equals the lost number.
	always_comb begin
		lost_found = 1'b0;
		lost_slot  = '0;
		for (int i = RD - 1; i >= 0; i--) begin
			if (tags_q[i] == cmd.seq_number) begin
				lost_found = 1'b1;
				lost_slot  = PW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < RD; i++) begin
			tags_n[i] = tags_q[i];
		end
		head_n        = head_q;
		tail_n        = tail_q;
		next_seq_n    = next_seq_q;
		last_ack_n    = last_ack_q;
		ack_seen_n    = ack_seen_q;
		next_qseq_n   = next_qseq_q;
		window_n      = window_q;
		partner_cur_n = partner_cur_q;
		partner_end_n = partner_end_q;
		tag_gap       = '0;
		res           = '0;
		res.status_code = cwmt_pkg::ST_OK;

		case (cmd.op)
			cwmt_pkg::OP_ADD: begin
				if (ring_full) begin
					res.status_code = cwmt_pkg::ST_RING_FULL;
				end else begin
					tags_n[head_q] = next_seq_q;
					res.slot       = head_q;
					res.msg_seq    = next_seq_q;
					res.accepted   = 1'b1;
					next_seq_n     = next_seq_q + TW'(1);
					head_n         = head_q + PW'(1);
				end
			end
			cwmt_pkg::OP_SEND: begin
				if (head_q == tail_q) begin
					res.status_code = cwmt_pkg::ST_EMPTY;
				end else if (window_q < win_min_q) begin
					res.status_code = cwmt_pkg::ST_WINDOW;
				end else if (move_q[tail_q] && (fill > dev_limit_q)) begin
					res.status_code = cwmt_pkg::ST_DEVQ_FULL;
				end else begin
					if (move_q[tail_q]) begin
						res.queue_seq = next_qseq_q;
						res.sequenced = 1'b1;
						next_qseq_n   = next_qseq_q + QW'(1);
					end
					if (window_q != '0) begin
						window_n = window_q - TW'(1);
					end
					res.slot     = tail_q;
					res.msg_seq  = tags_q[tail_q];
					res.accepted = 1'b1;
					tail_n       = tail_q + PW'(1);
				end
			end
			cwmt_pkg::OP_ACK: begin
				if (!(ack_seen_q && (last_ack_q == cmd.seq_number))) begin
					ack_seen_n = 1'b1;
					last_ack_n = cmd.seq_number;
					// Keep only tags in the window just above the acked number.
					for (int i = 0; i < RD; i++) begin
						tag_gap = tags_q[i] - cmd.seq_number - TW'(1);
						if ((tags_q[i] != '0) && (tag_gap >= TW'(RD))) begin
							tags_n[i] = '0;
						end
					end
				end
			end
			cwmt_pkg::OP_LOST: begin
				if (lost_found) begin
					tail_n = lost_slot;
				end else begin
					next_seq_n = resync_seq;
					head_n     = resync_seq[PW-1:0];
					tail_n     = resync_seq[PW-1:0];
				end
			end
			cwmt_pkg::OP_PURGE: begin
				head_n     = tail_q;
				next_seq_n = resync_seq;
				for (int i = 0; i < RD; i++) begin
					tags_n[i] = '0;
				end
			end
			cwmt_pkg::OP_RESET: begin
				head_n      = '0;
				tail_n      = '0;
				next_seq_n  = last_ack_q;
				next_qseq_n = partner_end_q;
				for (int i = 0; i < RD; i++) begin
					tags_n[i] = '0;
				end
			end
			cwmt_pkg::OP_STATUS: begin
				window_n      = cmd.window_credit;
				partner_cur_n = cmd.device_current_qseq;
				partner_end_n = cmd.device_end_qseq;
			end
			default: begin
			end
		endcase

		held              = head_n - tail_n;
		res.messages_held = held;
		if ((tags_n[head_n] != '0) || (int'(held) > cwmt_pkg::QUEUE_SPAN)) begin
			res.queue_left = '0;
		end else begin
			res.queue_left = PW'(cwmt_pkg::QUEUE_SPAN) - held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RD; i++) begin
				tags_q[i] <= '0;
			end
			head_q        <= '0;
			tail_q        <= '0;
			next_seq_q    <= '0;
			last_ack_q    <= '0;
			ack_seen_q    <= 1'b0;
			next_qseq_q   <= '0;
			window_q      <= '0;
			partner_cur_q <= '0;
			partner_end_q <= '0;
			dev_limit_q   <= cwmt_pkg::DEVICE_QUEUE_LIMIT_RESET;
			win_min_q     <= cwmt_pkg::WINDOW_MINIMUM_RESET;
		end else begin
			if (exec) begin
				for (int i = 0; i < RD; i++) begin
					tags_q[i] <= tags_n[i];
				end
				head_q        <= head_n;
				tail_q        <= tail_n;
				next_seq_q    <= next_seq_n;
				last_ack_q    <= last_ack_n;
				ack_seen_q    <= ack_seen_n;
				next_qseq_q   <= next_qseq_n;
				window_q      <= window_n;
				partner_cur_q <= partner_cur_n;
				partner_end_q <= partner_end_n;
			end
			if (cfg_valid) begin
				case (cfg_index)
					cwmt_pkg::REG_DEVICE_QUEUE_LIMIT: dev_limit_q <= cfg_data;
					cwmt_pkg::REG_WINDOW_MINIMUM:     win_min_q   <= cfg_data[TW-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// The kind flag has no reset: the user must read a slot only after an add wrote it; the block does not enforce it.
	always_ff @(posedge clk) begin
		if (add_ok) begin
			move_q[head_q] <= cmd.is_move;
		end
	end

`ifndef NO_ASSERTIONS
	a_add_advances_head: assert property (@(posedge clk) disable iff (!arst_n)
		add_ok |=> head_q == $past(head_q) + PW'(1))
		else $error("accepted add did not advance the head");

	a_accept_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.accepted |-> res.status_code == cwmt_pkg::ST_OK)
		else $error("accepted request reports an error code");

	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> ({1'b0, res.messages_held} + {1'b0, res.queue_left})
			<= (PW + 1)'(cwmt_pkg::QUEUE_SPAN) || res.queue_left == '0)
		else $error("queue space and held count disagree");

	a_stamp_only_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.sequenced |-> res.accepted && cmd.op == cwmt_pkg::OP_SEND)
		else $error("queue sequence stamped outside an accepted send");
`endif

endmodule

// File: sim/tb_credit_window_message_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Credit window message tracker testbench
// A table of directed requests followed by six phases of random traffic, each
// under its own register setting. Every accepted request is run through a
// local model of the ring, window and queue counters, and every popped result
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_credit_window_message_tracker;

	typedef logic [cwmt_pkg::PTR_W-1:0] ptr_t;

	localparam int RANDOM_PER_PHASE = 205;
	localparam int PHASES           = 6;
	localparam int CYCLE_LIMIT      = 600000;
	// Idle wait after the last expected result, to cover anything still moving
	// through the block.
	localparam int DRAIN_CYCLES     = 8;
	// Number of requests after which the result side goes quiet for a while.
	localparam int HOLD_AFTER       = 300;
	localparam int HOLD_CYCLES      = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        push;
	logic        full;
	logic [2:0]  opcode;
	logic [2:0]  msg_kind;
	logic [7:0]  seq_number;
	logic [7:0]  window_credit;
	logic [15:0] device_current_qseq;
	logic [15:0] device_end_qseq;

	logic        empty;
	logic        pop;
	logic        accepted;
	logic [2:0]  status_code;
	logic [2:0]  slot;
	logic [7:0]  msg_seq;
	logic [15:0] queue_seq;
	logic        sequenced;
	logic [2:0]  messages_held;
	logic [2:0]  queue_left;

	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	credit_window_message_tracker uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.push                (push),
		.full                (full),
		.opcode              (opcode),
		.msg_kind            (msg_kind),
		.seq_number          (seq_number),
		.window_credit       (window_credit),
		.device_current_qseq (device_current_qseq),
		.device_end_qseq     (device_end_qseq),
		.empty               (empty),
		.pop                 (pop),
		.accepted            (accepted),
		.status_code         (status_code),
		.slot                (slot),
		.msg_seq             (msg_seq),
		.queue_seq           (queue_seq),
		.sequenced           (sequenced),
		.messages_held       (messages_held),
		.queue_left          (queue_left),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Local copy of the tracker's state. kind_valid marks slots whose kind has
	// been written at least once; the block's kind store is not cleared by
	// reset, so a send must never land on a slot that was never filled.
	// ------------------------------------------------------------------------
	logic [cwmt_pkg::TAG_W-1:0]  tag_mem   [cwmt_pkg::RING_DEPTH];
	logic [cwmt_pkg::KIND_W-1:0] kind_mem  [cwmt_pkg::RING_DEPTH];
	bit                          kind_valid[cwmt_pkg::RING_DEPTH];
	ptr_t                        head_p;
	ptr_t                        tail_p;
	logic [cwmt_pkg::TAG_W-1:0]  next_tag;
	logic [cwmt_pkg::TAG_W-1:0]  acked_tag;
	logic [cwmt_pkg::TAG_W-1:0]  sent_tag;
	bit                          ack_valid;
	logic [cwmt_pkg::QSEQ_W-1:0] next_qseq;
	logic [cwmt_pkg::TAG_W-1:0]  credit_left;
	logic [cwmt_pkg::QSEQ_W-1:0] dev_cur;
	logic [cwmt_pkg::QSEQ_W-1:0] dev_end;
	logic [cwmt_pkg::QSEQ_W-1:0] qlimit_reg;
	logic [cwmt_pkg::TAG_W-1:0]  wmin_reg;

	// Predicted results, oldest first.
	cwmt_pkg::res_t expected_results[$];

	int   errors         = 0;
	int   requests_taken = 0;
	int   results_seen   = 0;
	int   sends_done     = 0;
	int   settings_used  = 0;
	int   cycle_count    = 0;
	bit   hold_done      = 0;

	// Directed requests. Rows with typed set carry a result written out by
	// hand; the others take the prediction.
	typedef struct {
		cwmt_pkg::op_t  op;
		logic [2:0]     kind;
		logic [7:0]     seqn;
		logic [7:0]     credit;
		logic [15:0]    cur;
		logic [15:0]    endq;
		bit             typed;
		cwmt_pkg::res_t res;
	} plan_row_t;

	plan_row_t plan[$];

	// Applies one request to the local state and returns what the block must
	// answer. Rejected adds and sends leave the state untouched.
	function automatic cwmt_pkg::res_t track_request(input cwmt_pkg::op_t opc,
			input logic [2:0] kind, input logic [7:0] seqn, input logic [7:0] credit,
			input logic [15:0] cur, input logic [15:0] endq);
		cwmt_pkg::res_t              r;
		ptr_t                        nxt;
		ptr_t                        held_p;
		logic [cwmt_pkg::QSEQ_W-1:0] fill;
		logic [cwmt_pkg::TAG_W-1:0]  tag_gap;
		bit                          go;
		bit                          move;
		bit                          found;
		int                          left;
		int                          x;
		r = '0;
		r.status_code = cwmt_pkg::ST_OK;
		case (opc)
			cwmt_pkg::OP_ADD: begin
				nxt = head_p + ptr_t'(1);
				if (nxt == tail_p) begin
					r.status_code = cwmt_pkg::ST_RING_FULL;
				end else begin
					tag_mem[head_p]    = next_tag;
					kind_mem[head_p]   = kind;
					kind_valid[head_p] = 1'b1;
					r.accepted = 1'b1;
					r.slot     = head_p;
					r.msg_seq  = next_tag;
					next_tag   = next_tag + 8'd1;
					head_p     = nxt;
				end
			end
			cwmt_pkg::OP_SEND: begin
				go = 1'b0;
				move = 1'b0;
				if (head_p == tail_p) begin
					r.status_code = cwmt_pkg::ST_EMPTY;
				end else if (credit_left < wmin_reg) begin
					r.status_code = cwmt_pkg::ST_WINDOW;
				end else begin
					go = 1'b1;
					move = (kind_mem[tail_p] <= cwmt_pkg::KIND_DWELL);
					fill = dev_end - dev_cur;
					if (move && fill > qlimit_reg) begin
						r.status_code = cwmt_pkg::ST_DEVQ_FULL;
						go = 1'b0;
					end
				end
				if (go) begin
					if (move) begin
						r.queue_seq = next_qseq;
						r.sequenced = 1'b1;
						next_qseq   = next_qseq + 16'd1;
					end
					// The credit count saturates at zero when the minimum is zero.
					if (credit_left != '0)
						credit_left = credit_left - 8'd1;
					r.accepted = 1'b1;
					r.slot     = tail_p;
					r.msg_seq  = tag_mem[tail_p];
					sent_tag   = tag_mem[tail_p];
					tail_p     = tail_p + ptr_t'(1);
				end
			end
			cwmt_pkg::OP_ACK: begin
				// A repeat of the last processed ack is ignored, but only once an
				// ack has been seen at all.
				if (!(ack_valid && acked_tag == seqn)) begin
					ack_valid = 1'b1;
					acked_tag = seqn;
					for (x = 0; x < cwmt_pkg::RING_DEPTH; x++) begin
						tag_gap = tag_mem[x] - seqn - 8'd1;
						if (tag_mem[x] != '0 && tag_gap >= 8'(cwmt_pkg::RING_DEPTH))
							tag_mem[x] = '0;
					end
				end
			end
			cwmt_pkg::OP_LOST: begin
				// The lowest matching slot wins, a tag of zero included.
				found = 1'b0;
				for (x = 0; x < cwmt_pkg::RING_DEPTH; x++) begin
					if (!found && tag_mem[x] == seqn) begin
						tail_p = ptr_t'(x);
						found = 1'b1;
					end
				end
				if (!found) begin
					next_tag = acked_tag + 8'd1;
					head_p   = next_tag[cwmt_pkg::PTR_W-1:0];
					tail_p   = head_p;
				end
			end
			cwmt_pkg::OP_PURGE: begin
				head_p   = tail_p;
				next_tag = acked_tag + 8'd1;
				for (x = 0; x < cwmt_pkg::RING_DEPTH; x++)
					tag_mem[x] = '0;
			end
			cwmt_pkg::OP_RESET: begin
				head_p    = '0;
				tail_p    = '0;
				sent_tag  = acked_tag;
				next_tag  = acked_tag;
				next_qseq = dev_end;
				for (x = 0; x < cwmt_pkg::RING_DEPTH; x++)
					tag_mem[x] = '0;
			end
			cwmt_pkg::OP_STATUS: begin
				credit_left = credit;
				dev_cur     = cur;
				dev_end     = endq;
			end
			default: begin
			end
		endcase
		held_p = head_p - tail_p;
		left = cwmt_pkg::RING_DEPTH - 2 - int'(held_p);
		if (tag_mem[head_p] != '0 || left < 0)
			left = 0;
		r.messages_held = held_p;
		r.queue_left    = ptr_t'(left);
		return r;
	endfunction

	function automatic cwmt_pkg::res_t known(input bit acc, input cwmt_pkg::status_t code,
			input ptr_t slot_n, input logic [7:0] mseq, input logic [15:0] qseq,
			input bit seqd, input ptr_t held, input ptr_t left);
		cwmt_pkg::res_t r;
		r.accepted      = acc;
		r.status_code   = code;
		r.slot          = slot_n;
		r.msg_seq       = mseq;
		r.queue_seq     = qseq;
		r.sequenced     = seqd;
		r.messages_held = held;
		r.queue_left    = left;
		return r;
	endfunction

	function automatic void plan_row(input cwmt_pkg::op_t op, input logic [2:0] kind,
			input logic [7:0] seqn, input logic [7:0] credit, input logic [15:0] cur,
			input logic [15:0] endq, input bit typed, input cwmt_pkg::res_t res);
		plan_row_t row;
		row.op     = op;
		row.kind   = kind;
		row.seqn   = seqn;
		row.credit = credit;
		row.cur    = cur;
		row.endq   = endq;
		row.typed  = typed;
		row.res    = res;
		plan.push_back(row);
	endfunction

	// Offers one request after a random idle gap and waits until the block
	// takes it. The prediction is made at the edge that accepts the request.
	task automatic issue(input cwmt_pkg::op_t op, input logic [2:0] kind,
			input logic [7:0] seqn, input logic [7:0] credit, input logic [15:0] cur,
			input logic [15:0] endq, input bit typed, input cwmt_pkg::res_t typed_res);
		int             gap;
		int             r;
		cwmt_pkg::res_t want;
		r = $urandom_range(0, 99);
		if (r < 50)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 40);
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push                <= 1'b1;
		opcode              <= op;
		msg_kind            <= kind;
		seq_number          <= seqn;
		window_credit       <= credit;
		device_current_qseq <= cur;
		device_end_qseq     <= endq;
		do
			@(posedge clk);
		while (full !== 1'b0);
		want = track_request(op, kind, seqn, credit, cur, endq);
		if (typed)
			want = typed_res;
		expected_results.push_back(want);
		requests_taken++;
		if (op == cwmt_pkg::OP_SEND && want.accepted)
			sends_done++;
	endtask

	// One write on the configuration channel; the local copy follows at the
	// edge that takes it.
	task automatic write_reg(input logic idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		if (idx == cwmt_pkg::REG_DEVICE_QUEUE_LIMIT)
			qlimit_reg = data;
		else
			wmin_reg = data[7:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side. Pops come in runs of random length, with one long hold once
	// enough requests have gone in, so both internal queues fill and the
	// request side sees full.
	// ------------------------------------------------------------------------
	initial begin : result_drain
		int run;
		int r;
		bit level;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!hold_done && requests_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				run = HOLD_CYCLES;
				level = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					level = 1'b1;
					run = $urandom_range(1, 40);
				end else if (r < 90) begin
					level = 1'b0;
					run = $urandom_range(1, 3);
				end else if (r < 98) begin
					level = 1'b0;
					run = $urandom_range(4, 20);
				end else begin
					level = 1'b0;
					run = $urandom_range(30, 60);
				end
			end
			repeat (run) begin
				@(negedge clk);
				pop <= level;
			end
		end
	end

	// Every popped result is matched against the oldest prediction.
	always @(posedge clk) begin : result_check
		cwmt_pkg::res_t want;
		if (arst_n && pop === 1'b1 && empty === 1'b0) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result popped with no request outstanding", $time);
				errors++;
			end else begin
				want = expected_results.pop_front();
				results_seen++;
				check_field("accepted", 16'(want.accepted), 16'(accepted));
				check_field("status_code", 16'(want.status_code), 16'(status_code));
				check_field("slot", 16'(want.slot), 16'(slot));
				check_field("msg_seq", 16'(want.msg_seq), 16'(msg_seq));
				check_field("queue_seq", want.queue_seq, queue_seq);
				check_field("sequenced", 16'(want.sequenced), 16'(sequenced));
				check_field("messages_held", 16'(want.messages_held),
					16'(messages_held));
				check_field("queue_left", 16'(want.queue_left), 16'(queue_left));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("tb_credit_window_message_tracker: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Request side: reset, the directed table, then the random phases.
	// ------------------------------------------------------------------------
	initial begin : request_source
		int            ph;
		int            n;
		int            r;
		int            t;
		cwmt_pkg::op_t op;
		logic [2:0]    kind;
		logic [7:0]    seqn;
		logic [7:0]    credit;
		logic [15:0]   cur;
		logic [15:0]   fill;
		logic [15:0]   lim;
		logic [7:0]    wmin;

		push                = 1'b0;
		opcode              = cwmt_pkg::OP_ADD;
		msg_kind            = cwmt_pkg::KIND_LINEAR;
		seq_number          = '0;
		window_credit       = '0;
		device_current_qseq = '0;
		device_end_qseq     = '0;
		cfg_valid           = 1'b0;
		cfg_index           = cwmt_pkg::REG_DEVICE_QUEUE_LIMIT;
		cfg_data            = '0;

		for (n = 0; n < cwmt_pkg::RING_DEPTH; n++) begin
			tag_mem[n]    = '0;
			kind_mem[n]   = cwmt_pkg::KIND_LINEAR;
			kind_valid[n] = 1'b0;
		end
		head_p      = '0;
		tail_p      = '0;
		next_tag    = '0;
		acked_tag   = '0;
		sent_tag    = '0;
		ack_valid   = 1'b0;
		next_qseq   = '0;
		credit_left = '0;
		dev_cur     = '0;
		dev_end     = '0;
		qlimit_reg  = cwmt_pkg::DEVICE_QUEUE_LIMIT_RESET;
		wmin_reg    = cwmt_pkg::WINDOW_MINIMUM_RESET;

		// Directed table, starting from the reset registers (limit 23, minimum 3).
		// Send on an empty ring, then the window and device queue refusals.
		plan_row(cwmt_pkg::OP_SEND, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1,
			known(1'b0, cwmt_pkg::ST_EMPTY, 3'd0, 8'd0, 16'd0, 1'b0, 3'd0, 3'd6));
		plan_row(cwmt_pkg::OP_ADD, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1,
			known(1'b1, cwmt_pkg::ST_OK, 3'd0, 8'd0, 16'd0, 1'b0, 3'd1, 3'd5));
		plan_row(cwmt_pkg::OP_SEND, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1,
			known(1'b0, cwmt_pkg::ST_WINDOW, 3'd0, 8'd0, 16'd0, 1'b0, 3'd1, 3'd5));
		plan_row(cwmt_pkg::OP_STATUS, 3'd0, 8'd0, 8'd255, 16'h0000, 16'hffff, 1'b1,
			known(1'b0, cwmt_pkg::ST_OK, 3'd0, 8'd0, 16'd0, 1'b0, 3'd1, 3'd5));
		plan_row(cwmt_pkg::OP_SEND, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1,
			known(1'b0, cwmt_pkg::ST_DEVQ_FULL, 3'd0, 8'd0, 16'd0, 1'b0, 3'd1, 3'd5));
		plan_row(cwmt_pkg::OP_STATUS, 3'd0, 8'd0, 8'd255, 16'd100, 16'd100, 1'b1,
			known(1'b0, cwmt_pkg::ST_OK, 3'd0, 8'd0, 16'd0, 1'b0, 3'd1, 3'd5));
		plan_row(cwmt_pkg::OP_SEND, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1,
			known(1'b1, cwmt_pkg::ST_OK, 3'd0, 8'd0, 16'd0, 1'b1, 3'd0, 3'd6));
		// Fill the ring with kinds one to four, seven and zero; a further add is refused.
		plan_row(cwmt_pkg::OP_ADD, 3'd1, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_ADD, 3'd2, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_ADD, 3'd3, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_ADD, 3'd4, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_ADD, 3'd7, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_ADD, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_ADD, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_ADD, 3'd5, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1,
			known(1'b0, cwmt_pkg::ST_RING_FULL, 3'd0, 8'd0, 16'd0, 1'b0, 3'd7, 3'd0));
		// Fill exactly at the limit, sends until the window runs short.
		plan_row(cwmt_pkg::OP_STATUS, 3'd0, 8'd0, 8'd4, 16'd0, 16'd23, 1'b0, '0);
		plan_row(cwmt_pkg::OP_SEND, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_SEND, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_SEND, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		// An ack, its repeat, lost on a held tag, on tag zero and on a missing tag.
		plan_row(cwmt_pkg::OP_ACK, 3'd0, 8'd2, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_ACK, 3'd0, 8'd2, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_LOST, 3'd0, 8'd3, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_LOST, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_LOST, 3'd0, 8'd255, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_PURGE, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_RESET, 3'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);
		plan_row(cwmt_pkg::OP_NONE, 3'd7, 8'hff, 8'hff, 16'hffff, 16'hffff, 1'b0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			issue(plan[i].op, plan[i].kind, plan[i].seqn, plan[i].credit,
				plan[i].cur, plan[i].endq, plan[i].typed, plan[i].res);

		for (ph = 0; ph < PHASES; ph++) begin
			// Registers change only once the block has gone quiet.
			@(negedge clk);
			push <= 1'b0;
			while (expected_results.size() != 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
			case (ph)
				0: begin
					lim = 16'd0;
					wmin = 8'd0;
				end
				1: begin
					lim = 16'hffff;
					wmin = 8'hff;
				end
				2: begin
					lim = 16'hffff;
					wmin = 8'd0;
				end
				3: begin
					lim = 16'd0;
					wmin = 8'hff;
				end
				4: begin
					lim = 16'($urandom_range(0, 40));
					wmin = 8'($urandom_range(0, 6));
				end
				default: begin
					lim = cwmt_pkg::DEVICE_QUEUE_LIMIT_RESET;
					wmin = cwmt_pkg::WINDOW_MINIMUM_RESET;
				end
			endcase
			write_reg(cwmt_pkg::REG_DEVICE_QUEUE_LIMIT, lim);
			// The upper byte is not part of the minimum; fill it with noise.
			write_reg(cwmt_pkg::REG_WINDOW_MINIMUM, {8'($urandom), wmin});
			settings_used++;

			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Mostly adds and sends paced by status updates, acks close to the last
				// sent tag and losses of tags still in the ring.
				r = $urandom_range(0, 99);
				if (r < 30)
					op = cwmt_pkg::OP_ADD;
				else if (r < 60)
					op = cwmt_pkg::OP_SEND;
				else if (r < 75)
					op = cwmt_pkg::OP_STATUS;
				else if (r < 87)
					op = cwmt_pkg::OP_ACK;
				else if (r < 94)
					op = cwmt_pkg::OP_LOST;
				else if (r < 96)
					op = cwmt_pkg::OP_PURGE;
				else if (r < 98)
					op = cwmt_pkg::OP_RESET;
				else
					op = cwmt_pkg::OP_NONE;
				kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
					: 3'($urandom_range(0, 4));
				seqn = 8'($urandom);
				credit = 8'($urandom);
				cur = 16'($urandom);
				fill = 16'($urandom);
				if (op == cwmt_pkg::OP_STATUS) begin
					t = $urandom_range(0, 9);
					if (t < 2)
						credit = 8'd0;
					else if (t < 4)
						credit = 8'hff;
					else if (t < 8)
						credit = 8'($urandom_range(1, 12));
					t = $urandom_range(0, 9);
					if (t < 3)
						fill = qlimit_reg;
					else if (t < 5)
						fill = qlimit_reg + 16'd1;
					else if (t < 8)
						fill = 16'($urandom_range(0, 8));
				end else if (op == cwmt_pkg::OP_ACK) begin
					if ($urandom_range(0, 9) < 7)
						seqn = sent_tag + 8'($urandom_range(0, 4)) - 8'd2;
				end else if (op == cwmt_pkg::OP_LOST) begin
					if ($urandom_range(0, 9) < 6)
						seqn = tag_mem[$urandom_range(0, cwmt_pkg::RING_DEPTH - 1)];
				end
				// A lost can leave the tail on a slot that never held a message;
				// clear the ring instead of sending from it.
				if (op == cwmt_pkg::OP_SEND && head_p != tail_p && !kind_valid[tail_p])
					op = cwmt_pkg::OP_PURGE;
				issue(op, kind, seqn, credit, cur, cur + fill, 1'b0, '0);
			end
		end

		@(negedge clk);
		push <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests, %0d of them accepted sends, across %0d register settings.",
			requests_taken, sends_done, settings_used + 1);
		$display("Compared %0d results field by field; %0d mismatches seen.",
			results_seen, errors);
		if (errors == 0)
			$display("tb_credit_window_message_tracker: clean");
		else
			$display("tb_credit_window_message_tracker: errors");
		$finish;
	end

endmodule
